// ===== rtl/markup_tag_comment_skipper_top_defines.svh =====
// Assertion macros for the markup tag and comment skipper.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef MARKUP_TAG_COMMENT_SKIPPER_TOP_DEFINES_SVH
`define MARKUP_TAG_COMMENT_SKIPPER_TOP_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define MTCS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle during reset.
`define MTCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mtcs_pkg.sv =====
// Shared types and byte codes for the markup tag and comment skipper.
// No dependencies.
package mtcs_pkg;

   typedef enum logic [3:0] {
      M_TEXT      = 4'd0,
      M_LT        = 4'd1,
      M_BANG      = 4'd2,
      M_BANGDASH  = 4'd3,
      M_TAG       = 4'd4,
      M_SQ        = 4'd5,
      M_DQ        = 4'd6,
      M_CBODY     = 4'd7,
      M_CDASH1    = 4'd8,
      M_CDASH2    = 4'd9,
      M_CDASH2WS  = 4'd10
   } mode_type;

   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      mode_type next_mode;
      logic     in_markup;
      logic     in_comment;
      logic     markup_end;
   } class_type;

endpackage

// ===== rtl/mtcs_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// No dependencies.
interface mtcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_document;

   modport source (output valid, output data_byte, output new_document, input ready);
   modport sink   (input valid, input data_byte, input new_document, output ready);
endinterface

interface mtcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       in_markup;
   logic       in_comment;
   logic       markup_end;

   modport source (output valid, output out_byte, output in_markup,
                   output in_comment, output markup_end, input ready);
   modport sink   (input valid, input out_byte, input in_markup,
                   input in_comment, input markup_end, output ready);
endinterface

// ===== rtl/mtcs_classify.sv =====
// Next-mode and label logic for one document byte.
// Depends on mtcs_pkg.
module mtcs_classify (
   input  mtcs_pkg::mode_type  mode,
   input  logic [7:0]          data_byte,
   output mtcs_pkg::class_type cls
);
   import mtcs_pkg::*;

   logic     is_ws;
   mode_type tag_mode;
   logic     tag_end;

   assign is_ws = (data_byte == CH_SPACE) || (data_byte inside {[CH_TAB:CH_CR]});

   // unquoted tag byte: open a quote, close the tag, or stay in the tag
   always_comb begin
      tag_end = 1'b0;
      if (data_byte == CH_SQUOTE) begin
         tag_mode = M_SQ;
      end else if (data_byte == CH_DQUOTE) begin
         tag_mode = M_DQ;
      end else if (data_byte == CH_GT) begin
         tag_mode = M_TEXT;
         tag_end  = 1'b1;
      end else begin
         tag_mode = M_TAG;
      end
   end

   always_comb begin
      cls.next_mode  = mode;
      cls.in_markup  = 1'b1;
      cls.in_comment = 1'b0;
      cls.markup_end = 1'b0;
      case (mode)
         M_LT: begin
            if (data_byte == CH_BANG) begin
               cls.next_mode = M_BANG;
            end else begin
               cls.next_mode  = tag_mode;
               cls.markup_end = tag_end;
            end
         end
         M_BANG: begin
            if (data_byte == CH_DASH) begin
               cls.next_mode = M_BANGDASH;
            end else begin
               cls.next_mode  = tag_mode;
               cls.markup_end = tag_end;
            end
         end
         M_BANGDASH: begin
            if (data_byte == CH_DASH) begin
               cls.next_mode = M_CBODY;
            end else begin
               cls.next_mode  = tag_mode;
               cls.markup_end = tag_end;
            end
         end
         M_TAG: begin
            cls.next_mode  = tag_mode;
            cls.markup_end = tag_end;
         end
         M_SQ: begin
            if (data_byte == CH_SQUOTE) cls.next_mode = M_TAG;
         end
         M_DQ: begin
            if (data_byte == CH_DQUOTE) cls.next_mode = M_TAG;
         end
         M_CBODY: begin
            cls.in_comment = 1'b1;
            cls.next_mode  = (data_byte == CH_DASH) ? M_CDASH1 : M_CBODY;
         end
         M_CDASH1: begin
            cls.in_comment = 1'b1;
            cls.next_mode  = (data_byte == CH_DASH) ? M_CDASH2 : M_CBODY;
         end
         M_CDASH2, M_CDASH2WS: begin
            cls.in_comment = 1'b1;
            if (data_byte == CH_GT) begin
               cls.next_mode  = M_TEXT;
               cls.markup_end = 1'b1;
            end else if (data_byte == CH_DASH) begin
               cls.next_mode = (mode == M_CDASH2) ? M_CDASH2 : M_CDASH1;
            end else if (is_ws) begin
               cls.next_mode = M_CDASH2WS;
            end else begin
               cls.next_mode = M_CBODY;
            end
         end
         default: begin
            if (data_byte == CH_LT) begin
               cls.next_mode = M_LT;
            end else begin
               cls.next_mode = M_TEXT;
               cls.in_markup = 1'b0;
            end
         end
      endcase
   end

endmodule

// ===== rtl/markup_tag_comment_skipper_top.sv =====
// Top level of the markup tag and comment skipper: input stage, mode register,
// result stage. Depends on mtcs_pkg, mtcs_if, mtcs_classify and the defines header.
//
// Labels each document byte as text, tag or comment and passes it through. One
// byte per cycle sustained while the response port is ready; an accepted byte
// moves through the input register, then the result register, to the response
// port. The four-bit mode register is updated as each byte moves into the result
// register, and a byte with new_document set is parsed from text mode. Backpressure
// on the response port fills both stages before the request side stalls.
module markup_tag_comment_skipper_top (
   input logic        clock,
   input logic        reset,
   mtcs_req_if.sink   req_if,
   mtcs_rsp_if.source rsp_if
);
   import mtcs_pkg::*;

`include "markup_tag_comment_skipper_top_defines.svh"

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_newdoc_ff;

   mode_type   mode_ff;
   mode_type   mode_in;
   class_type  cls;

   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_markup_ff;
   logic       out_comment_ff;
   logic       out_end_ff;

   logic       advance;
   logic       req_take;

   logic       comment_hold;
   logic       mode_in_comment;
   logic       stalled_full;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   assign mode_in = in_newdoc_ff ? M_TEXT : mode_ff;

   mtcs_classify u_classify (
      .mode      (mode_in),
      .data_byte (in_byte_ff),
      .cls       (cls)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= M_TEXT;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            mode_ff      <= cls.next_mode;
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff   <= req_if.data_byte;
         in_newdoc_ff <= req_if.new_document;
      end
      if (advance) begin
         out_byte_ff    <= in_byte_ff;
         out_markup_ff  <= cls.in_markup;
         out_comment_ff <= cls.in_comment;
         out_end_ff     <= cls.markup_end;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.out_byte   = out_byte_ff;
   assign rsp_if.in_markup  = out_markup_ff;
   assign rsp_if.in_comment = out_comment_ff;
   assign rsp_if.markup_end = out_end_ff;

   assign comment_hold    = advance && cls.in_comment && !cls.markup_end;
   assign mode_in_comment = mode_ff inside {M_CBODY, M_CDASH1, M_CDASH2, M_CDASH2WS};
   assign stalled_full    = in_valid_ff && out_valid_ff && !rsp_if.ready;

   `MTCS_ASSERT_NEXT(a_end_to_text, advance && cls.markup_end, mode_ff == M_TEXT, "tag left open")
   `MTCS_ASSERT_NEXT(a_comment_stays, comment_hold, mode_in_comment, "left comment early")
   `MTCS_ASSERT_NOW(a_stall_only_full, !req_if.ready, stalled_full, "request stalled with room")

endmodule

// ===== bench/tb_markup_tag_comment_skipper_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for markup_tag_comment_skipper_top: random and directed document
// bytes, predicted text/tag/comment labels, random stalls on both channels.
// Depends on mtcs_pkg, mtcs_if and the top level.
module tb_markup_tag_comment_skipper_top;
   import mtcs_pkg::*;

   typedef struct packed {
      logic [7:0] octet;
      logic       markup;
      logic       comment;
      logic       closing;
   } label_word_type;

   typedef struct {
      logic [7:0] octet;
      logic       fresh;
      logic       drain;
   } doc_item_type;

   logic clock;
   logic reset;

   mtcs_req_if req_if();
   mtcs_rsp_if rsp_if();

   markup_tag_comment_skipper_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   doc_item_type   stream_q[$];
   label_word_type label_q[$];
   mode_type       doc_mode = M_TEXT;
   logic           word_taken = 1'b0;
   logic           hold_rsp = 1'b0;
   logic           no_idle = 1'b0;
   int unsigned    req_gap = 0;
   int unsigned    rsp_stall = 0;
   int unsigned    accepted_count = 0;
   int unsigned    queued_count = 0;
   int unsigned    error_count = 0;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic ws_octet(logic [7:0] o);
      return o == CH_SPACE || (o >= CH_TAB && o <= CH_CR);
   endfunction

   function automatic logic tag_octet(logic [7:0] o);
      if (o == CH_SQUOTE) doc_mode = M_SQ;
      else if (o == CH_DQUOTE) doc_mode = M_DQ;
      else if (o == CH_GT) begin
         doc_mode = M_TEXT;
         return 1'b1;
      end else doc_mode = M_TAG;
      return 1'b0;
   endfunction

   function automatic label_word_type label_octet(logic [7:0] o, logic fresh);
      label_word_type w;
      w = '{octet: o, markup: 1'b1, comment: 1'b0, closing: 1'b0};
      if (fresh) doc_mode = M_TEXT;
      case (doc_mode)
         M_LT: begin
            if (o == CH_BANG) doc_mode = M_BANG;
            else w.closing = tag_octet(o);
         end
         M_BANG: begin
            if (o == CH_DASH) doc_mode = M_BANGDASH;
            else w.closing = tag_octet(o);
         end
         M_BANGDASH: begin
            if (o == CH_DASH) doc_mode = M_CBODY;
            else w.closing = tag_octet(o);
         end
         M_TAG: w.closing = tag_octet(o);
         M_SQ: if (o == CH_SQUOTE) doc_mode = M_TAG;
         M_DQ: if (o == CH_DQUOTE) doc_mode = M_TAG;
         M_CBODY: begin
            w.comment = 1'b1;
            if (o == CH_DASH) doc_mode = M_CDASH1;
         end
         M_CDASH1: begin
            w.comment = 1'b1;
            if (o == CH_DASH) doc_mode = M_CDASH2;
            else doc_mode = M_CBODY;
         end
         M_CDASH2, M_CDASH2WS: begin
            w.comment = 1'b1;
            if (o == CH_GT) begin
               doc_mode = M_TEXT;
               w.closing = 1'b1;
            end else if (o == CH_DASH) begin
               if (doc_mode == M_CDASH2WS) doc_mode = M_CDASH1;
            end else if (ws_octet(o)) doc_mode = M_CDASH2WS;
            else doc_mode = M_CBODY;
         end
         default: begin
            if (o == CH_LT) doc_mode = M_LT;
            else begin
               doc_mode = M_TEXT;
               w.markup = 1'b0;
            end
         end
      endcase
      return w;
   endfunction

   function automatic logic [7:0] pick_octet();
      case ($urandom_range(0, 14))
         0, 1, 2, 3: return 8'($urandom_range(0, 255));
         4: return CH_LT;
         5: return CH_GT;
         6: return CH_BANG;
         7, 8: return CH_DASH;
         9: return CH_SQUOTE;
         10: return CH_DQUOTE;
         11: return CH_SPACE;
         12: return 8'($urandom_range(CH_TAB, CH_CR));
         13: return ($urandom_range(0, 1) != 0) ? 8'h08 : 8'h0E;
         default: return 8'h80 | 8'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [7:0] pick_space();
      return ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
   endfunction

   task automatic add_octet(logic [7:0] o, logic fresh, logic drain);
      doc_item_type item;
      item = '{octet: o, fresh: fresh, drain: drain};
      stream_q.insert(stream_q.size(), item);
      queued_count++;
   endtask

   task automatic add_text(string s, logic fresh);
      for (int i = 0; i < s.len(); i++) add_octet(s[i], fresh && i == 0, 1'b0);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // alternate stretches with and without idling
   initial begin
      forever begin
         repeat ($urandom_range(50, 200)) @(posedge clock);
         no_idle <= ($urandom_range(0, 3) == 0);
      end
   end

   // long response hold-off once the stream is well underway
   initial begin
      while (accepted_count < 200) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (80) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      label_word_type w;
      word_taken <= !reset && req_if.valid && req_if.ready;
      if (reset) doc_mode = M_TEXT;
      else if (req_if.valid && req_if.ready) begin
         w = label_octet(req_if.data_byte, req_if.new_document);
         label_q.insert(label_q.size(), w);
         accepted_count++;
      end
   end

   always @(negedge clock) begin
      doc_item_type item;
      if (reset) req_if.valid <= 1'b0;
      else if (!req_if.valid || word_taken) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_if.valid <= 1'b0;
         end else if (stream_q.size() == 0 ||
                      (stream_q[0].drain && label_q.size() != 0)) begin
            req_if.valid <= 1'b0;
         end else begin
            item = stream_q.pop_front();
            req_if.data_byte <= item.octet;
            req_if.new_document <= item.fresh;
            req_if.valid <= 1'b1;
            req_gap <= pick_gap();
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_if.ready <= 1'b0;
      else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_stall <= pick_gap();
      end
   end

   always @(posedge clock) begin
      label_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (label_q.size() == 0) begin
            $display("%0t: unexpected word, got byte %h", $time, rsp_if.out_byte);
            error_count++;
         end else begin
            want = label_q.pop_front();
            if (want.octet !== rsp_if.out_byte)
               $display("%0t: out_byte expected %h got %h", $time, want.octet,
                        rsp_if.out_byte);
            if (want.markup !== rsp_if.in_markup)
               $display("%0t: in_markup expected %b got %b (byte %h)", $time, want.markup,
                        rsp_if.in_markup, want.octet);
            if (want.comment !== rsp_if.in_comment)
               $display("%0t: in_comment expected %b got %b (byte %h)", $time, want.comment,
                        rsp_if.in_comment, want.octet);
            if (want.closing !== rsp_if.markup_end)
               $display("%0t: markup_end expected %b got %b (byte %h)", $time, want.closing,
                        rsp_if.markup_end, want.octet);
            if ({want.octet, want.markup, want.comment, want.closing} !==
                {rsp_if.out_byte, rsp_if.in_markup, rsp_if.in_comment, rsp_if.markup_end})
               error_count++;
         end
      end
   end

   initial begin
      int unsigned next_drain;
      int unsigned n;
      int unsigned dashes;
      logic [7:0]  o;
      logic [7:0]  quote;
      logic        fresh;
      logic        drain;

      reset = 1'b1;

      // opener hyphens do not close, whitespace then a lone hyphen restarts the count
      add_text("<!-->", 1'b1);
      add_text("-- ->", 1'b0);
      add_text("-->", 1'b0);
      add_text("<!", 1'b0);
      add_text("<'>'\">\">", 1'b1);
      add_text("<!>", 1'b0);
      add_octet(8'h00, 1'b0, 1'b0);
      add_octet(8'hFF, 1'b0, 1'b0);

      next_drain = 325;
      while (queued_count < 640) begin
         fresh = ($urandom_range(0, 24) == 0);
         drain = (queued_count >= next_drain);
         if (drain) next_drain += 250;
         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  do o = pick_octet(); while (o == CH_LT);
                  add_octet(o, fresh, drain);
                  fresh = 1'b0;
                  drain = 1'b0;
               end
            end
            2, 3, 4: begin
               add_octet(CH_LT, fresh, drain);
               n = $urandom_range(0, 6);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) begin
                     quote = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
                     add_octet(quote, 1'b0, 1'b0);
                     repeat ($urandom_range(0, 4)) begin
                        do o = pick_octet(); while (o == quote);
                        add_octet(o, 1'b0, 1'b0);
                     end
                     add_octet(quote, 1'b0, 1'b0);
                  end else begin
                     do o = pick_octet();
                     while (o == CH_GT || o == CH_SQUOTE || o == CH_DQUOTE);
                     add_octet(o, 1'b0, 1'b0);
                  end
               end
               add_octet(CH_GT, 1'b0, 1'b0);
            end
            5, 6, 7: begin
               add_octet(CH_LT, fresh, drain);
               add_text("!--", 1'b0);
               repeat ($urandom_range(0, 10)) add_octet(pick_octet(), 1'b0, 1'b0);
               dashes = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 2;
               repeat (dashes) add_octet(CH_DASH, 1'b0, 1'b0);
               if ($urandom_range(0, 2) == 0)
                  repeat ($urandom_range(1, 3)) add_octet(pick_space(), 1'b0, 1'b0);
               add_octet(CH_GT, 1'b0, 1'b0);
            end
            8: begin
               add_octet(CH_LT, fresh, drain);
               add_octet(CH_BANG, 1'b0, 1'b0);
               if ($urandom_range(0, 1) != 0) add_octet(CH_DASH, 1'b0, 1'b0);
               do o = pick_octet(); while (o == CH_DASH);
               add_octet(o, 1'b0, 1'b0);
               add_octet(CH_GT, 1'b0, 1'b0);
            end
            default: begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  add_octet(pick_octet(), fresh || $urandom_range(0, 9) == 0, drain);
                  fresh = 1'b0;
                  drain = 1'b0;
               end
            end
         endcase
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stream_q.size() != 0 || req_if.valid || label_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
